// ===== rtl/core/lrbc_pkg.sv =====
// Shared types, constants and helpers of the layered RGB blend compositor.
package lrbc_pkg;

    // Channel, pixel and fixed-point widths.
    localparam int CHAN_W           = 8;
    localparam int RGB_W            = 3 * CHAN_W;
    localparam int FRAC_W           = 8;
    localparam int ACC_W            = CHAN_W + FRAC_W;
    localparam int Q8_W             = 9;
    localparam int NUM_LAYER_INPUTS = 4;
    localparam int CFG_IDX_W        = 3;

    // One in Q8.
    localparam logic [Q8_W-1:0] Q8_ONE = 9'd256;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY   = 3'd0,
        CFG_ENABLE  = 3'd1,
        CFG_FACTOR0 = 3'd2,
        CFG_FACTOR1 = 3'd3,
        CFG_FACTOR2 = 3'd4,
        CFG_FACTOR3 = 3'd5
    } t_cfg_idx;

    // Per-channel accumulator, Q8.8 unsigned.
    typedef logic [ACC_W-1:0] t_acc;

    // Payload that travels down the pipeline: red, green, blue accumulators
    // and the layer pixels still to be blended.
    typedef struct packed {
        t_acc [2:0]                           acc;
        logic [NUM_LAYER_INPUTS-1:0][RGB_W-1:0] lay;
    } t_beat;

    // Clamp a Q8 weight to full weight.
    function automatic logic [Q8_W-1:0] sat_q8(input logic [Q8_W-1:0] v);
        return (v > Q8_ONE) ? Q8_ONE : v;
    endfunction

endpackage

// ===== rtl/core/lrbc_layer_stage.sv =====
// One pipeline stage that blends one layer over the running accumulators.
module lrbc_layer_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  lrbc_pkg::t_beat               i_beat,
    input  logic [lrbc_pkg::RGB_W-1:0]    i_layer_rgb,
    input  logic                          i_enable,
    input  logic [lrbc_pkg::Q8_W-1:0]     i_factor,
    output logic                          o_valid,
    input  logic                          i_ready,
    output lrbc_pkg::t_beat               o_beat
);

    logic                           r_valid;
    lrbc_pkg::t_beat                r_beat;
    lrbc_pkg::t_beat                n_beat;
    logic [lrbc_pkg::Q8_W-1:0]      w_keep;
    logic [2:0][24:0]               w_p_keep;
    logic [2:0][24:0]               w_p_new;
    logic [2:0][25:0]               w_sum;

    // The stage takes a beat when it is empty or its beat moves on.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    // Blend: acc*(1-f) + layer*f, truncated back to Q8.8.
    assign w_keep = lrbc_pkg::Q8_ONE - i_factor;

    always_comb begin
        n_beat = i_beat;
        for (int ch = 0; ch < 3; ch++) begin
            w_p_keep[ch] = {9'd0, i_beat.acc[ch]} * {16'd0, w_keep};
            w_p_new[ch]  = {9'd0, i_layer_rgb[(2-ch)*lrbc_pkg::CHAN_W +: lrbc_pkg::CHAN_W],
                            8'd0} * {16'd0, i_factor};
            w_sum[ch]    = {1'b0, w_p_keep[ch]} + {1'b0, w_p_new[ch]};
            if (i_enable) begin
                n_beat.acc[ch] = w_sum[ch][23:8];
            end
        end
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

// ===== rtl/core/layered_rgb_blend_compositor.sv =====
// Top level of the layered RGB blend compositor pipeline.
//
//  Channel   Dir   Handshake                  Payload
//  s_*       in    s_tvalid / s_tready        s_tdata: app, layer0..layer3 pixels
//  m_*       out   m_tvalid / m_tready        m_tdata: red, green, blue
//  cfg       in    i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One pixel enters per clock while the output is not stalled. The stages: one
// stage scales the application pixel, one stage per layer runs the blend
// multiplies, and one output register holds the result.
// Reset clears the valid bits and the configuration registers.
// Each stage holds its beat while the next one is full and stalled, so a
// bubble anywhere in the pipeline is filled while the output waits.
module layered_rgb_blend_compositor #(
    parameter int LAYER_COUNT = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [lrbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lrbc_pkg::Q8_W-1:0]         i_cfg_data,
    // Input pixel stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: app_rgb, layer0_rgb, layer1_rgb, layer2_rgb, layer3_rgb.
    input  logic [119:0]                      s_tdata,
    // Output pixel stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: out_red, out_green, out_blue.
    output logic [23:0]                       m_tdata
);

    localparam int LAYERS = (LAYER_COUNT < lrbc_pkg::NUM_LAYER_INPUTS) ?
                            LAYER_COUNT : lrbc_pkg::NUM_LAYER_INPUTS;
    localparam int RGB_W  = lrbc_pkg::RGB_W;
    localparam int CHAN_W = lrbc_pkg::CHAN_W;

    // Configuration registers, weights kept already clamped to one.
    logic [lrbc_pkg::Q8_W-1:0]                                 r_decay;
    logic [lrbc_pkg::NUM_LAYER_INPUTS-1:0]                     r_enable;
    logic [lrbc_pkg::NUM_LAYER_INPUTS-1:0][lrbc_pkg::Q8_W-1:0] r_factor;

    // Pipeline links: index k is the output of stage k.
    lrbc_pkg::t_beat w_beat  [0:LAYERS];
    logic            w_valid [0:LAYERS];
    logic            w_ready [0:LAYERS];

    // Entry stage.
    logic                       r_v0;
    lrbc_pkg::t_beat            r_b0;
    lrbc_pkg::t_beat            n_b0;
    logic [lrbc_pkg::Q8_W-1:0]  w_app_keep;
    logic [2:0][16:0]           w_app_prod;

    // Output register.
    logic                       r_out_valid;
    logic [RGB_W-1:0]           r_out_data;
    logic [RGB_W-1:0]           n_out_data;
    logic                       w_out_ready;

    // Configuration decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= '0;
            r_enable <= '0;
            r_factor <= '0;
        end else if (i_cfg_we) begin
            unique case (lrbc_pkg::t_cfg_idx'(i_cfg_idx))
                lrbc_pkg::CFG_DECAY:   r_decay     <= lrbc_pkg::sat_q8(i_cfg_data);
                lrbc_pkg::CFG_ENABLE:  r_enable    <= i_cfg_data[lrbc_pkg::NUM_LAYER_INPUTS-1:0];
                lrbc_pkg::CFG_FACTOR0: r_factor[0] <= lrbc_pkg::sat_q8(i_cfg_data);
                lrbc_pkg::CFG_FACTOR1: r_factor[1] <= lrbc_pkg::sat_q8(i_cfg_data);
                lrbc_pkg::CFG_FACTOR2: r_factor[2] <= lrbc_pkg::sat_q8(i_cfg_data);
                lrbc_pkg::CFG_FACTOR3: r_factor[3] <= lrbc_pkg::sat_q8(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Entry stage: scale the application pixel by one minus the decay.
    assign w_app_keep = lrbc_pkg::Q8_ONE - r_decay;

    always_comb begin
        for (int v = 0; v < lrbc_pkg::NUM_LAYER_INPUTS; v++) begin
            n_b0.lay[v] = s_tdata[(v+1)*RGB_W +: RGB_W];
        end
        for (int ch = 0; ch < 3; ch++) begin
            w_app_prod[ch] = {9'd0, s_tdata[(2-ch)*CHAN_W +: CHAN_W]} * {8'd0, w_app_keep};
            n_b0.acc[ch]   = w_app_prod[ch][lrbc_pkg::ACC_W-1:0];
        end
    end

    assign s_tready = !r_v0 || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (s_tready) begin
            r_v0 <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_b0 <= n_b0;
        end
    end

    assign w_valid[0] = r_v0;
    assign w_beat[0]  = r_b0;

    // One blend stage per layer, layer zero first.
    for (genvar v = 0; v < LAYERS; v++) begin : g_layer
        lrbc_layer_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_valid[v]),
            .o_ready     (w_ready[v]),
            .i_beat      (w_beat[v]),
            .i_layer_rgb (w_beat[v].lay[v]),
            .i_enable    (r_enable[v]),
            .i_factor    (r_factor[v]),
            .o_valid     (w_valid[v+1]),
            .i_ready     (w_ready[v+1]),
            .o_beat      (w_beat[v+1])
        );
    end

    // Output register. The accumulator never exceeds 255*256, so its integer
    // part is already within the 8-bit channel range.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_out_data[ch*CHAN_W +: CHAN_W] =
                w_beat[LAYERS].acc[ch][lrbc_pkg::ACC_W-1:lrbc_pkg::FRAC_W];
        end
    end

    assign w_out_ready     = !r_out_valid || m_tready;
    assign w_ready[LAYERS] = w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[LAYERS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_valid[LAYERS]) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // The input only backs up when every stage is full and the output is stalled.
    a_backpressure_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (m_tvalid && !m_tready)
    ) else $error("input stalled while the pipeline has room");

    // A result only appears after the last blend stage held a beat.
    a_out_from_pipeline: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(w_valid[LAYERS])
    ) else $error("output beat appeared without a source beat");

    // Reset empties the output.
    a_reset_empties: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !m_tvalid
    ) else $error("output valid right after reset");

endmodule

// ===== tb/layered_rgb_blend_compositor_checker.sv =====
// Checker for the layered RGB blend compositor: tracks registers, predicts pixels, compares.
module layered_rgb_blend_compositor_checker
    import lrbc_pkg::*;
#(
    parameter int LAYER_COUNT = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [Q8_W-1:0]                        i_cfg_data,
    input  logic                                   i_s_tvalid,
    input  logic                                   i_s_tready,
    // Fields from bit 0: app_rgb, layer0_rgb, layer1_rgb, layer2_rgb, layer3_rgb.
    input  logic [RGB_W*(NUM_LAYER_INPUTS+1)-1:0]  i_s_tdata,
    input  logic                                   i_m_tvalid,
    input  logic                                   i_m_tready,
    // Fields from bit 0: out_red, out_green, out_blue.
    input  logic [RGB_W-1:0]                       i_m_tdata,
    output int                                     o_mismatch_count,
    output int                                     o_pending_count
);

    localparam int BLENDED_LAYERS =
        (LAYER_COUNT < NUM_LAYER_INPUTS) ? LAYER_COUNT : NUM_LAYER_INPUTS;
    localparam int REPORT_LIMIT = 10;

    // One output pixel; red sits in the lowest byte.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_out_pixel;

    // Shadow copy of the configuration registers.
    logic [Q8_W-1:0]             app_decay;
    logic [NUM_LAYER_INPUTS-1:0] layer_mask;
    logic [Q8_W-1:0]             layer_weight [NUM_LAYER_INPUTS];

    t_out_pixel blended_q [$];
    int         mismatch_total;

    // Weights above one count as full weight.
    function automatic logic [31:0] clamp_weight(input logic [Q8_W-1:0] w);
        return (w > Q8_ONE) ? 32'(Q8_ONE) : 32'(w);
    endfunction

    // Decay the application pixel, then blend each enabled layer over it.
    function automatic t_out_pixel blend_pixel(input logic [RGB_W*(NUM_LAYER_INPUTS+1)-1:0] beat);
        logic [31:0]       acc;
        logic [31:0]       weight;
        logic [31:0]       chan;
        logic [31:0]       lay_chan;
        logic [CHAN_W-1:0] res [3];
        t_out_pixel        pix;
        for (int c = 0; c < 3; c++) begin
            chan = 32'(beat[c*CHAN_W +: CHAN_W]);
            acc  = chan * (32'(Q8_ONE) - clamp_weight(app_decay));
            for (int v = 0; v < BLENDED_LAYERS; v++) begin
                if (layer_mask[v]) begin
                    weight   = clamp_weight(layer_weight[v]);
                    lay_chan = 32'(beat[(v+1)*RGB_W + c*CHAN_W +: CHAN_W]);
                    acc = (acc * (32'(Q8_ONE) - weight) + (lay_chan << FRAC_W) * weight)
                          >> FRAC_W;
                end
            end
            acc = acc >> FRAC_W;
            res[c] = (acc > 32'd255) ? 8'hFF : acc[CHAN_W-1:0];
        end
        pix.blue  = res[0];
        pix.green = res[1];
        pix.red   = res[2];
        return pix;
    endfunction

    // Compare output beats, queue predictions for input beats, follow register writes.
    always @(posedge i_clk) begin
        t_out_pixel got;
        t_out_pixel want;
        if (!i_rst_n) begin
            app_decay  <= '0;
            layer_mask <= '0;
            for (int v = 0; v < NUM_LAYER_INPUTS; v++) layer_weight[v] <= '0;
            blended_q.delete();
            mismatch_total = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (blended_q.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("%0t: pixel out with none pending: r=%02h g=%02h b=%02h",
                                 $time, got.red, got.green, got.blue);
                end else begin
                    want = blended_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT)
                            $display({"%0t: pixel mismatch: expected r=%02h g=%02h b=%02h,",
                                      " got r=%02h g=%02h b=%02h"}, $time,
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                blended_q.push_back(blend_pixel(i_s_tdata));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DECAY:   app_decay       <= i_cfg_data;
                    CFG_ENABLE:  layer_mask      <= i_cfg_data[NUM_LAYER_INPUTS-1:0];
                    CFG_FACTOR0: layer_weight[0] <= i_cfg_data;
                    CFG_FACTOR1: layer_weight[1] <= i_cfg_data;
                    CFG_FACTOR2: layer_weight[2] <= i_cfg_data;
                    CFG_FACTOR3: layer_weight[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_mismatch_count <= mismatch_total;
        o_pending_count  <= blended_q.size();
    end

endmodule

// ===== tb/layered_rgb_blend_compositor_test.sv =====
// Top of the compositor testbench: clock, reset, stimulus, back-pressure and verdict.
module layered_rgb_blend_compositor_test;
    import lrbc_pkg::*;

    localparam int LAYER_COUNT     = 4;
    localparam int PIXEL_W         = RGB_W * (NUM_LAYER_INPUTS + 1);
    localparam int PIPE_LATENCY    =
        ((LAYER_COUNT < NUM_LAYER_INPUTS) ? LAYER_COUNT : NUM_LAYER_INPUTS) + 2;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int BURST_PIXELS    = 48;
    localparam int SETTINGS_PER_PHASE = 3;
    localparam int PIXELS_PER_SETTING = 40;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [Q8_W-1:0]      i_cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIXEL_W-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [RGB_W-1:0]     m_tdata;

    int mismatch_count;
    int pending_count;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_off_start     = 1'b0;
    int elapsed_cycles     = 0;

    layered_rgb_blend_compositor #(
        .LAYER_COUNT (LAYER_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    layered_rgb_blend_compositor_checker #(
        .LAYER_COUNT (LAYER_COUNT)
    ) blend_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    always #2 i_clk = ~i_clk;

    // Run-away guard.
    always @(posedge i_clk) begin
        elapsed_cycles <= elapsed_cycles + 1;
        if (elapsed_cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_start) begin
                hold_off_start = 1'b0;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge i_clk);
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Channel values lean toward black and full intensity.
    function automatic logic [CHAN_W-1:0] random_chan();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [RGB_W-1:0] random_rgb();
        return {random_chan(), random_chan(), random_chan()};
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        return {random_rgb(), random_rgb(), random_rgb(), random_rgb(), random_rgb()};
    endfunction

    // Q8 weights: zero, one, over-range, or anything in between.
    function automatic logic [Q8_W-1:0] random_weight();
        case ($urandom_range(5))
            0:       return '0;
            1:       return Q8_ONE;
            2:       return Q8_W'($urandom_range(511, 257));
            default: return Q8_W'($urandom_range(255, 1));
        endcase
    endfunction

    // Offer one beat after a random gap and hold it until it is taken.
    task automatic send_pixel(input logic [PIXEL_W-1:0] pixel);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stop offering and wait until every predicted pixel has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // One register write; the caller drops the write enable afterwards.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [Q8_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Load all registers, then poke the undecoded indexes with junk.
    task automatic load_setting(input logic [Q8_W-1:0] decay_val,
                                input logic [Q8_W-1:0] enable_val,
                                input logic [Q8_W-1:0] w0, input logic [Q8_W-1:0] w1,
                                input logic [Q8_W-1:0] w2, input logic [Q8_W-1:0] w3);
        cfg_write(CFG_DECAY,   decay_val);
        cfg_write(CFG_ENABLE,  enable_val);
        cfg_write(CFG_FACTOR0, w0);
        cfg_write(CFG_FACTOR1, w1);
        cfg_write(CFG_FACTOR2, w2);
        cfg_write(CFG_FACTOR3, w3);
        cfg_write(CFG_UNUSED_LO, Q8_W'($urandom_range(511)));
        cfg_write(CFG_UNUSED_HI, Q8_W'($urandom_range(511)));
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_setting();
        load_setting(random_weight(), Q8_W'($urandom_range(511)), random_weight(),
                     random_weight(), random_weight(), random_weight());
    endtask

    // A block of random traffic under one idling profile.
    task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold_off);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
            drain();
            load_random_setting();
            for (int n = 0; n < PIXELS_PER_SETTING; n++) send_pixel(random_pixel());
        end
        if (with_hold_off) begin
            // Back-to-back beats into a stalled output fill the pipeline.
            drain();
            hold_off_start  = 1'b1;
            sender_idle_pct = 0;
            for (int n = 0; n < BURST_PIXELS; n++) send_pixel(random_pixel());
            sender_idle_pct = idle_pct;
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_DECAY;
        i_cfg_data <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: the application pixel passes through untouched.
        send_pixel({{4{24'hA5C33C}}, 24'h000000});
        send_pixel({random_rgb(), random_rgb(), random_rgb(), random_rgb(), 24'hFFFFFF});

        // Full decay with layer 0 at full weight: layer 0 replaces the pixel.
        drain();
        load_setting(9'd256, 9'h001, 9'd256, 9'd0, 9'd0, 9'd0);
        send_pixel({{3{24'h123456}}, 24'h00FF00, 24'hFFFFFF});
        send_pixel({{3{24'hFFFFFF}}, 24'hFF00FF, 24'h000000});

        // Decay above one saturates; enabled layers at zero weight leave black.
        drain();
        load_setting(9'd511, 9'h1FF, 9'd0, 9'd0, 9'd0, 9'd0);
        send_pixel({5{24'hFFFFFF}});
        send_pixel({random_rgb(), random_rgb(), random_rgb(), random_rgb(), random_rgb()});

        // Over-range weights saturate; the last layer at full weight wins.
        drain();
        load_setting(9'd0, 9'h00F, 9'd511, 9'd300, 9'd257, 9'd256);
        send_pixel({24'h00FF80, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h808080});
        send_pixel({random_rgb(), random_rgb(), random_rgb(), random_rgb(), random_rgb()});

        // Half decay with a sparse enable pattern.
        drain();
        load_setting(9'd128, 9'h0A5, 9'd128, 9'd511, 9'd64, 9'd200);
        send_pixel({5{24'hFFFFFF}});
        send_pixel({5{24'h000000}});
        send_pixel({24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF});

        // Weights one step off the ends.
        drain();
        load_setting(9'd1, 9'h00F, 9'd1, 9'd255, 9'd1, 9'd255);
        send_pixel({5{24'hFFFFFF}});
        send_pixel({24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h010101});
        send_pixel({24'hFEFEFE, 24'h7F7F7F, 24'h808080, 24'h010101, 24'hFEFEFE});

        // Nearly full decay, odd layers only.
        drain();
        load_setting(9'd255, 9'h10A, 9'd0, 9'd128, 9'd511, 9'd32);
        send_pixel({5{24'hFFFFFF}});
        send_pixel({24'h0F0F0F, 24'hF0F0F0, 24'h00FF00, 24'hFF00FF, 24'hFFFFFF});

        // Random traffic under each idling profile.
        run_phase(0, 0, 1'b1);
        run_phase(87, 0, 1'b0);
        run_phase(0, 87, 1'b0);
        run_phase(14, 14, 1'b1);

        drain();
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
